/* sv/adr_pkg.sv */
// adr_pkg: widths, constants, command and status types of the dead-reckoning core.
// No dependencies; every other file uses it.
`timescale 1ns / 1ps

package adr_pkg;

  localparam int SampleW          = 16;
  localparam int FieldW           = 32;
  localparam int SumW             = 23;
  localparam int GainW            = 32;
  localparam int DbW              = 31;
  localparam int TsW              = 16;
  localparam int RunW             = 8;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 32;

  localparam int SamplesPerResult = 25;
  localparam int CntW             = $clog2(SamplesPerResult + 1);

  // averaging: round(prod / (SamplesPerResult * 2^8)) done as
  // ((|prod| + half) >> 8) / SamplesPerResult
  localparam int AvgShift         = 8;
  localparam int DivHalf          = (SamplesPerResult << AvgShift) / 2;
  // scaled magnitude clamped where the quotient reaches 2^31 (saturates either sign)
  localparam longint ScaledMax    = longint'(SamplesPerResult) << 31;
  localparam int ScaledW          = $clog2(ScaledMax + 1);
  // floor(y / SamplesPerResult) = (y * RcpMul) >> RcpShift for y < 2^ScaledW
  localparam int RcpShift         = ScaledW + $clog2(SamplesPerResult);
  localparam int RcpW             = ScaledW + 1;
  localparam int RcpLoW           = RcpW / 2;
  localparam int RcpHiW           = RcpW - RcpLoW;
  localparam int RcpPW            = ScaledW + RcpHiW;
  localparam int RcpAccW          = ScaledW + RcpW;
  localparam logic [RcpW-1:0] RcpMul =
    RcpW'(((longint'(1) << RcpShift) + SamplesPerResult - 1) / SamplesPerResult);
  localparam int MagW             = 40;

  localparam int MulAW            = 34;
  localparam int MulBW            = 33;
  localparam int ProdW            = 56;
  localparam int TrapShift        = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN = 3'd0,
    CFG_DB_X = 3'd1,
    CFG_DB_Y = 3'd2,
    CFG_DB_Z = 3'd3,
    CFG_TS   = 3'd4,
    CFG_ZRL  = 3'd5
  } adr_cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACC,
    CMD_MUL_GAIN,
    CMD_DIV_INIT,
    CMD_RCP_LO,
    CMD_RCP_HI,
    CMD_ACCEL,
    CMD_MUL_TV,
    CMD_ROUND,
    CMD_VEL,
    CMD_MUL_TP,
    CMD_POS,
    CMD_LOAD
  } adr_cmd_e;

  typedef struct packed {
    adr_cmd_e   op;
    logic [1:0] axis;
  } adr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } adr_sts_t;

endpackage

/* sv/adr_in_if.sv */
// adr_in_if: sample channel, one beat carries one raw sample per axis.
// Depends on adr_pkg.
`timescale 1ns / 1ps

interface adr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [adr_pkg::SampleW-1:0]  sample_x;
  logic signed [adr_pkg::SampleW-1:0]  sample_y;
  logic signed [adr_pkg::SampleW-1:0]  sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

/* sv/adr_out_if.sv */
// adr_out_if: result channel, one beat per completed sample block.
// Depends on adr_pkg.
`timescale 1ns / 1ps

interface adr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [adr_pkg::FieldW-1:0]  accel_x;
  logic signed [adr_pkg::FieldW-1:0]  accel_y;
  logic signed [adr_pkg::FieldW-1:0]  accel_z;
  logic signed [adr_pkg::FieldW-1:0]  velocity_x;
  logic signed [adr_pkg::FieldW-1:0]  velocity_y;
  logic signed [adr_pkg::FieldW-1:0]  velocity_z;
  logic signed [adr_pkg::FieldW-1:0]  position_x;
  logic signed [adr_pkg::FieldW-1:0]  position_y;
  logic signed [adr_pkg::FieldW-1:0]  position_z;

  modport source (output valid, accel_x, accel_y, accel_z, velocity_x, velocity_y,
                  velocity_z, position_x, position_y, position_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, velocity_x, velocity_y,
                  velocity_z, position_x, position_y, position_z, output ready);
endinterface

/* sv/adr_ctrl.sv */
// adr_ctrl: sequencer; counts samples, then walks each axis through the datapath.
// Depends on adr_pkg.
`timescale 1ns / 1ps

module adr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output adr_pkg::adr_cmd_t cmd_o,
  input  adr_pkg::adr_sts_t sts_i
);
  import adr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_G, S_DIV_INIT, S_RCP_LO, S_RCP_HI, S_ACCEL, S_MUL_TV, S_RND_V,
    S_VEL, S_MUL_TP, S_RND_P, S_POS, S_PUSH
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        axis_q;
  logic              in_beat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_beat ? CMD_ACC : CMD_NONE;
      S_MUL_G:    cmd_o.op = CMD_MUL_GAIN;
      S_DIV_INIT: cmd_o.op = CMD_DIV_INIT;
      S_RCP_LO:   cmd_o.op = CMD_RCP_LO;
      S_RCP_HI:   cmd_o.op = CMD_RCP_HI;
      S_ACCEL:    cmd_o.op = CMD_ACCEL;
      S_MUL_TV:   cmd_o.op = CMD_MUL_TV;
      S_RND_V:    cmd_o.op = CMD_ROUND;
      S_VEL:      cmd_o.op = CMD_VEL;
      S_MUL_TP:   cmd_o.op = CMD_MUL_TP;
      S_RND_P:    cmd_o.op = CMD_ROUND;
      S_POS:      cmd_o.op = CMD_POS;
      S_PUSH:     cmd_o.op = sts_i.out_busy ? CMD_NONE : CMD_LOAD;
      default:    cmd_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            if (cnt_q == CntW'(SamplesPerResult - 1)) begin
              cnt_q   <= '0;
              axis_q  <= '0;
              state_q <= S_MUL_G;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_MUL_G:    state_q <= S_DIV_INIT;
        S_DIV_INIT: state_q <= S_RCP_LO;
        S_RCP_LO:   state_q <= S_RCP_HI;
        S_RCP_HI:   state_q <= S_ACCEL;
        S_ACCEL:    state_q <= S_MUL_TV;
        S_MUL_TV:   state_q <= S_RND_V;
        S_RND_V:    state_q <= S_VEL;
        S_VEL:      state_q <= S_MUL_TP;
        S_MUL_TP:   state_q <= S_RND_P;
        S_RND_P:    state_q <= S_POS;
        S_POS: begin
          if (axis_q == 2'd2) begin
            state_q <= S_PUSH;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= S_MUL_G;
          end
        end
        S_PUSH: begin
          if (!sts_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == CMD_LOAD |-> !sts_i.out_busy) else $error("load into busy output");
  a_axis_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("axis out of range");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(SamplesPerResult)) else $error("sample count overrun");

endmodule

/* sv/adr_dp.sv */
// adr_dp: datapath; sums, shared multiplier, reciprocal divide, integrators, output register.
// Depends on adr_pkg; driven by adr_ctrl commands.
`timescale 1ns / 1ps

module adr_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  adr_pkg::adr_cmd_t                    cmd_i,
  output adr_pkg::adr_sts_t                    sts_o,
  input  logic                                 cfg_we_i,
  input  logic [adr_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [adr_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic signed [adr_pkg::SampleW-1:0]   sample_x_i,
  input  logic signed [adr_pkg::SampleW-1:0]   sample_y_i,
  input  logic signed [adr_pkg::SampleW-1:0]   sample_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [adr_pkg::FieldW-1:0]    accel_o [3],
  output logic signed [adr_pkg::FieldW-1:0]    velocity_o [3],
  output logic signed [adr_pkg::FieldW-1:0]    position_o [3]
);
  import adr_pkg::*;

  localparam logic [MagW-1:0] MaxPos = MagW'(64'h7FFF_FFFF);
  localparam logic [MagW-1:0] MinMag = MagW'(64'h8000_0000);
  localparam logic signed [FieldW-1:0] SMax = 32'sh7FFF_FFFF;
  localparam logic signed [FieldW-1:0] SMin = 32'sh8000_0000;

  // signed saturate from sign and magnitude
  function automatic logic signed [FieldW-1:0] sat_mag(input logic neg,
                                                      input logic [MagW-1:0] q);
    logic signed [FieldW-1:0] r;
    if (!neg) r = (q > MaxPos) ? SMax : FieldW'(q);
    else      r = (q >= MinMag) ? SMin : -$signed(FieldW'(q));
    return r;
  endfunction

  function automatic logic signed [FieldW-1:0] sat_add(input logic signed [FieldW-1:0] a,
                                                      input logic signed [FieldW-1:0] b);
    logic signed [FieldW:0] s;
    logic signed [FieldW-1:0] r;
    s = (FieldW+1)'(a) + (FieldW+1)'(b);
    if (s[FieldW] != s[FieldW-1]) r = s[FieldW] ? SMin : SMax;
    else r = s[FieldW-1:0];
    return r;
  endfunction

  logic [GainW-1:0]          gain_q;
  logic [DbW-1:0]            db_q [3];
  logic [TsW-1:0]            ts_q;
  logic [RunW-1:0]           zrl_q;

  logic signed [SumW-1:0]    sum_q [3];
  logic signed [FieldW-1:0]  prev_a_q [3];
  logic signed [FieldW-1:0]  vel_q [3];
  logic signed [FieldW-1:0]  prev_v_q [3];
  logic signed [FieldW-1:0]  pos_q [3];
  logic [RunW-1:0]           runs_q [3];

  logic signed [ProdW-1:0]   prod_q;
  logic [ScaledW-1:0]        y_q;
  logic [RcpAccW-1:0]        rcp_q;
  logic                      neg_q;
  logic signed [FieldW-1:0]  a_q, t_q, vnew_q;
  logic signed [FieldW-1:0]  res_a_q [3], res_v_q [3], res_p_q [3];
  logic                      out_valid_q;

  logic [1:0]                ax;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [MulAW+MulBW-1:0] mul_p;
  logic signed [SampleW-1:0] smp [3];

  logic [ProdW-1:0]          prod_mag;
  logic [ProdW-1:0]          y_full;
  logic [ScaledW-1:0]        y_clamp;
  logic [RcpHiW-1:0]         rcp_half;
  logic [RcpPW-1:0]          rcp_prod;
  logic [MagW-1:0]           quot;
  logic signed [FieldW-1:0]  a_sat;
  logic [FieldW:0]           a_mag;
  logic signed [FieldW-1:0]  a_db;
  logic [ProdW-1:0]          rnd_sum;
  logic signed [FieldW-1:0]  t_rnd;
  logic [RunW-1:0]           runs_new;
  logic signed [FieldW-1:0]  v_fin;

  assign ax     = cmd_i.axis;
  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign smp[2] = sample_z_i;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      CMD_MUL_GAIN: begin
        mul_a = MulAW'(sum_q[ax]);
        mul_b = $signed(MulBW'(gain_q));
      end
      CMD_MUL_TV: begin
        mul_a = MulAW'(prev_a_q[ax]) + MulAW'(a_q);
        mul_b = $signed(MulBW'(ts_q));
      end
      CMD_MUL_TP: begin
        mul_a = MulAW'(prev_v_q[ax]) + MulAW'(vnew_q);
        mul_b = $signed(MulBW'(ts_q));
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);

  // block-size divide: round and drop the gain fraction, clamp, then multiply by
  // the reciprocal in two halves (low half first, high half accumulated)
  assign y_full   = (prod_mag + ProdW'(DivHalf)) >> AvgShift;
  assign y_clamp  = (y_full > ProdW'(ScaledMax)) ? ScaledW'(ScaledMax) : ScaledW'(y_full);
  assign rcp_half = (cmd_i.op == CMD_RCP_HI) ? RcpHiW'(RcpMul >> RcpLoW) :
                                               RcpHiW'(RcpMul[RcpLoW-1:0]);
  assign rcp_prod = RcpPW'(y_q) * RcpPW'(rcp_half);
  assign quot     = MagW'(rcp_q >> RcpShift);

  assign a_sat = sat_mag(neg_q, quot);
  assign a_mag = a_sat[FieldW-1] ? -{1'b1, a_sat} : {1'b0, a_sat};
  assign a_db  = (a_mag <= (FieldW+1)'(db_q[ax])) ? '0 : a_sat;

  assign rnd_sum = prod_mag + ProdW'(1 << (TrapShift - 1));
  assign t_rnd   = sat_mag(prod_q[ProdW-1], MagW'(rnd_sum >> TrapShift));

  assign runs_new = (a_q != '0) ? '0 :
                    (runs_q[ax] == '1) ? runs_q[ax] : runs_q[ax] + 1'b1;
  assign v_fin    = (runs_new >= zrl_q) ? '0 : vnew_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainW'(99440);
      db_q[0] <= DbW'(13763);
      db_q[1] <= DbW'(13107);
      db_q[2] <= DbW'(19661);
      ts_q   <= TsW'(1311);
      zrl_q  <= RunW'(12);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN: gain_q  <= cfg_data_i[GainW-1:0];
        CFG_DB_X: db_q[0] <= cfg_data_i[DbW-1:0];
        CFG_DB_Y: db_q[1] <= cfg_data_i[DbW-1:0];
        CFG_DB_Z: db_q[2] <= cfg_data_i[DbW-1:0];
        CFG_TS:   ts_q    <= cfg_data_i[TsW-1:0];
        CFG_ZRL:  zrl_q   <= cfg_data_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // per-axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i]    <= '0;
        prev_a_q[i] <= '0;
        vel_q[i]    <= '0;
        prev_v_q[i] <= '0;
        pos_q[i]    <= '0;
        runs_q[i]   <= '0;
      end
    end else begin
      case (cmd_i.op)
        CMD_ACC: begin
          for (int i = 0; i < 3; i++) sum_q[i] <= sum_q[i] + SumW'(smp[i]);
        end
        CMD_POS: begin
          pos_q[ax]    <= sat_add(pos_q[ax], t_q);
          vel_q[ax]    <= v_fin;
          prev_v_q[ax] <= v_fin;
          prev_a_q[ax] <= a_q;
          runs_q[ax]   <= runs_new;
          sum_q[ax]    <= '0;
        end
        default: ;
      endcase
    end
  end

  // work registers and results
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_MUL_GAIN, CMD_MUL_TV, CMD_MUL_TP: prod_q <= mul_p[ProdW-1:0];
      CMD_DIV_INIT: begin
        neg_q <= prod_q[ProdW-1];
        y_q   <= y_clamp;
      end
      CMD_RCP_LO: rcp_q <= RcpAccW'(rcp_prod);
      CMD_RCP_HI: rcp_q <= rcp_q + (RcpAccW'(rcp_prod) << RcpLoW);
      CMD_ACCEL: a_q    <= a_db;
      CMD_ROUND: t_q    <= t_rnd;
      CMD_VEL:   vnew_q <= sat_add(vel_q[ax], t_q);
      CMD_POS: begin
        res_a_q[ax] <= a_q;
        res_v_q[ax] <= v_fin;
        res_p_q[ax] <= sat_add(pos_q[ax], t_q);
      end
      CMD_LOAD: begin
        accel_o    <= res_a_q;
        velocity_o <= res_v_q;
        position_o <= res_p_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.op == CMD_LOAD) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

/* sv/accel_dead_reckoning_core.sv */
// accel_dead_reckoning_core: top level, block-averaged dead reckoning with ZUPT.
// Depends on adr_pkg, adr_in_if, adr_out_if, adr_ctrl, adr_dp.
`timescale 1ns / 1ps
//
// channel   dir  beat content
// in_s      in   sample_x/y/z, raw 16-bit readings
// out_m     out  accel, velocity, position per axis, Q16.16
// cfg_*     in   register write, index + data, no handshake
//
// Sample beats are accepted while the sequencer is idle. The beat that
// completes a block of SamplesPerResult starts a pass over the three axes
// (per axis: gain multiply, round and clamp, reciprocal divide by the block
// size in two halves, dead band, then multiply/round/add for each trapezoid
// step), then the output register load; intake is closed until that load.
// Reset clears all integrators, run counters and sums; registers get defaults.
// A result waiting on out_m does not stop sample intake; if the next block
// finishes first, its load and with it intake wait until the old beat is taken.

module accel_dead_reckoning_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  adr_in_if.sink                        in_s,
  adr_out_if.source                     out_m,
  input  logic                          cfg_we_i,
  input  logic [adr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [adr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import adr_pkg::*;

  adr_cmd_t                 cmd;
  adr_sts_t                 sts;
  logic signed [FieldW-1:0] accel [3];
  logic signed [FieldW-1:0] velocity [3];
  logic signed [FieldW-1:0] position [3];

  adr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_s.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  adr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_x_i  (in_s.sample_x),
    .sample_y_i  (in_s.sample_y),
    .sample_z_i  (in_s.sample_z),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .accel_o     (accel),
    .velocity_o  (velocity),
    .position_o  (position)
  );

  assign out_m.accel_x    = accel[0];
  assign out_m.accel_y    = accel[1];
  assign out_m.accel_z    = accel[2];
  assign out_m.velocity_x = velocity[0];
  assign out_m.velocity_y = velocity[1];
  assign out_m.velocity_z = velocity[2];
  assign out_m.position_x = position[0];
  assign out_m.position_y = position[1];
  assign out_m.position_z = position[2];

endmodule

/* tb/tb_accel_dead_reckoning_core.sv */
// tb_accel_dead_reckoning_core: self-checking bench for the dead-reckoning core.
// Depends on adr_pkg, adr_in_if, adr_out_if and accel_dead_reckoning_core.
`timescale 1ns / 1ps

module tb_accel_dead_reckoning_core;
  import adr_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int PassLatency   = 3 * 11 + 10;

  typedef struct packed {
    logic signed [FieldW-1:0] ax, ay, az, vx, vy, vz, px, py, pz;
  } nav_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  adr_in_if  in_ch ();
  adr_out_if out_ch ();

  accel_dead_reckoning_core i_dut (
    .clk_i, .rst_ni, .in_s(in_ch), .out_m(out_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers and integrators, kept as in the block.
  // ---------------------------------------------------------------------------
  logic [31:0]        gain_q;
  logic [30:0]        dband_q [3];
  logic [15:0]        tstep_q;
  logic [7:0]         zlimit_q;
  longint             blk_sum [3];
  int                 blk_cnt;
  logic signed [31:0] acc_prev [3], vel_q [3], vel_prev [3], pos_q [3];
  logic [7:0]         zrun [3];

  nav_beat_t nav_expected [$];
  bit        failed;
  int        idle_cycles;
  bit        rx_stall_on;  // receiver backpressure enable

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // round half away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint trap_step(longint a, longint b);
    return clip32(div_round((a + b) * longint'(tstep_q), 131072));
  endfunction

  task automatic nav_reset_model();
    gain_q = 32'd99440;
    dband_q[0] = 31'd13763; dband_q[1] = 31'd13107; dband_q[2] = 31'd19661;
    tstep_q = 16'd1311;
    zlimit_q = 8'd12;
    blk_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      blk_sum[i] = 0; acc_prev[i] = '0; vel_q[i] = '0;
      vel_prev[i] = '0; pos_q[i] = '0; zrun[i] = '0;
    end
  endtask

  task automatic nav_predict(logic signed [15:0] s [3]);
    longint a, mag, v, p;
    logic signed [31:0] res [9];
    nav_beat_t e;
    for (int i = 0; i < 3; i++) blk_sum[i] += longint'(s[i]);
    blk_cnt++;
    if (blk_cnt < SamplesPerResult) return;
    for (int i = 0; i < 3; i++) begin
      a = clip32(div_round(blk_sum[i] * longint'(gain_q), SamplesPerResult * 256));
      mag = (a < 0) ? -a : a;
      if (mag <= longint'(dband_q[i])) a = 0;
      v = clip32(longint'(vel_q[i]) + trap_step(acc_prev[i], a));
      p = clip32(longint'(pos_q[i]) + trap_step(vel_prev[i], v));
      if (a == 0) begin
        if (zrun[i] != 8'd255) zrun[i]++;
      end else begin
        zrun[i] = '0;
      end
      if (zrun[i] >= zlimit_q) v = 0;  // zero-velocity update
      vel_q[i] = 32'(v); pos_q[i] = 32'(p); acc_prev[i] = 32'(a); vel_prev[i] = 32'(v);
      blk_sum[i] = 0;
      res[i] = 32'(a); res[3+i] = 32'(v); res[6+i] = 32'(p);
    end
    blk_cnt = 0;
    e = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8]};
    nav_expected.push_back(e);
  endtask

  // Gap length: mostly short, sometimes long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one sample beat, with an optional random gap in front. Valid stays high
  // between back-to-back beats; drain() drops it.
  // ---------------------------------------------------------------------------
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit gaps);
    int g;
    logic signed [15:0] s [3];
    g = gaps ? pick_gap() : 0;
    @(negedge clk_i);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_x <= x;
    in_ch.sample_y <= y;
    in_ch.sample_z <= z;
    do @(posedge clk_i); while (!in_ch.ready);
    s[0] = x; s[1] = y; s[2] = z;
    nav_predict(s);
  endtask

  task automatic send_block(int kind);
    for (int k = 0; k < SamplesPerResult; k++) begin
      case (kind)
        0: send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        1: send_sample(16'($urandom_range(0, 7) - 3), 16'($urandom_range(0, 7) - 3),
                       16'($urandom_range(0, 7) - 3), 1'b1);   // near rest
        default: send_sample(16'sh7fff, -16'sh8000, 16'($urandom), 1'b1);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes happen only with the block idle.
  // ---------------------------------------------------------------------------
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (nav_expected.size() != 0) @(negedge clk_i);
    repeat (PassLatency) @(negedge clk_i);
  endtask

  task automatic write_reg(adr_cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN: gain_q = val;
      CFG_DB_X: dband_q[0] = val[30:0];
      CFG_DB_Y: dband_q[1] = val[30:0];
      CFG_DB_Z: dband_q[2] = val[30:0];
      CFG_TS:   tstep_q = val[15:0];
      CFG_ZRL:  zlimit_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes under default settings, then a still spell that crosses
  // the zero-run limit and clears velocity.
  task automatic test_extremes();
    send_sample(16'sh7fff, -16'sh8000, 16'sh0000, 1'b0);
    send_sample(-16'sh8000, 16'sh7fff, 16'shffff, 1'b0);
    send_sample(16'sh0001, 16'sh5555, -16'sh5556, 1'b0);
    for (int k = 3; k < SamplesPerResult; k++)
      send_sample(16'sh7fff, 16'sh7fff, -16'sh8000, 1'b1);
    for (int b = 0; b < 14; b++) send_block(1);
    drain();
  endtask

  // Huge gain drives acceleration to both rails, the most negative one
  // passing any dead band; position integrators of the axes it drives saturate.
  task automatic test_saturation();
    write_reg(CFG_GAIN, 32'hffff_ffff);
    write_reg(CFG_DB_X, 32'h7fff_ffff);
    write_reg(CFG_DB_Y, 32'h0);
    write_reg(CFG_DB_Z, 32'h7fff_ffff);
    write_reg(CFG_TS, 32'h0000_ffff);
    write_reg(CFG_ZRL, 32'd255);
    for (int b = 0; b < 8; b++) send_block(2);
    drain();
  endtask

  // Zero time step and zero gain: integrators hold, accelerations vanish.
  task automatic test_zero_step_gain();
    write_reg(CFG_TS, 32'd0);
    send_block(0);
    drain();
    write_reg(CFG_TS, 32'd1);
    write_reg(CFG_GAIN, 32'd0);
    write_reg(CFG_ZRL, 32'd1);
    send_block(0);
    send_block(0);
    drain();
  endtask

  // Random register settings, mostly random blocks with some near-rest ones.
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_GAIN, (ph % 3 == 0) ? $urandom : $urandom_range(0, 400000));
      write_reg(CFG_DB_X, $urandom_range(0, 30000));
      write_reg(CFG_DB_Y, (ph == 5) ? 32'h7fff_ffff : $urandom_range(0, 30000));
      write_reg(CFG_DB_Z, $urandom_range(0, 30000));
      write_reg(CFG_TS, (ph == 2) ? 32'hffff : $urandom_range(1, 65535));
      write_reg(CFG_ZRL, (ph == 4) ? 32'd1 : $urandom_range(1, 8));
      rx_stall_on = (ph % 4) != 3;
      for (int b = 0; b < 3; b++) send_block(($urandom_range(0, 3) == 0) ? 1 : 0);
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls while rx_stall_on is set; compares every result beat.
  // ---------------------------------------------------------------------------
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = rx_stall_on ? pick_gap() : 0;
      @(negedge clk_i);
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    nav_beat_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.accel_x, out_ch.accel_y, out_ch.accel_z,
              out_ch.velocity_x, out_ch.velocity_y, out_ch.velocity_z,
              out_ch.position_x, out_ch.position_y, out_ch.position_z};
      if (nav_expected.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        failed = 1'b1;
      end else begin
        want = nav_expected.pop_front();
        check_field("accel_x", want.ax, got.ax);
        check_field("accel_y", want.ay, got.ay);
        check_field("accel_z", want.az, got.az);
        check_field("velocity_x", want.vx, got.vx);
        check_field("velocity_y", want.vy, got.vy);
        check_field("velocity_z", want.vz, got.vz);
        check_field("position_x", want.px, got.px);
        check_field("position_y", want.py, got.py);
        check_field("position_z", want.pz, got.pz);
      end
    end
  end

  // Watchdog: cycles without any accepted beat while something is pending.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i ||
        (nav_expected.size() == 0 && !in_ch.valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    failed = 1'b0;
    idle_cycles = 0;
    rx_stall_on = 1'b1;
    nav_reset_model();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_saturation();
    test_zero_step_gain();
    test_random_phases();
    drain();
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
